>>> rtl/i2crm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2crm_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_DEVICE_ADDRESS = 1'b0;

   localparam logic [6:0] DEV_ADDR_RESET = 7'h5A;
   localparam logic [5:0] MAX_READ_LEN   = 6'd32;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START1,
      PH_TX_ADDRW,
      PH_TX_REG,
      PH_TX_DATA,
      PH_START2,
      PH_TX_ADDRR,
      PH_RX,
      PH_STOP_OK,
      PH_STOP_ERR
   } phase_type;

   typedef struct packed {
      logic       func;
      logic       is_read;
      logic [7:0] reg_index;
      logic [7:0] write_data;
      logic [5:0] read_count;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       data_valid;
      logic [7:0] read_data;
      logic       last_byte;
      logic       done_res;
      logic       nack_error;
   } rsp_item_type;

endpackage

>>> rtl/i2crm_seq.sv
// Bit-level I2C sequencer: advances one half period per tick transaction.
module i2crm_seq
   import i2crm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic [6:0]   dev_addr,
   output rsp_item_type result
);

   phase_type  phase_ff, phase_in;
   logic [1:0] half_ff, half_in;
   logic [3:0] bits_ff, bits_in;
   logic [7:0] shift_ff, shift_in;
   logic [5:0] left_ff, left_in;
   logic       kind_ff, kind_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] value_ff, value_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic       scl_mid, sda_mid;
   logic       scl_low_next, sda_high_next;
   logic       dv, last, done, nack;
   logic [7:0] rd;
   logic [7:0] rx_shift;
   logic [5:0] left_dec;

   assign rx_shift = {shift_ff[6:0], item.sda_in};
   assign left_dec = (left_ff != 6'd0) ? left_ff - 6'd1 : left_ff;

   // line levels and per-transaction result flags
   always_comb begin
      scl_mid       = scl_ff;
      sda_mid       = sda_ff;
      scl_low_next  = 1'b0;
      sda_high_next = 1'b0;
      dv            = 1'b0;
      rd            = 8'd0;
      last          = 1'b0;
      done          = 1'b0;
      nack          = 1'b0;
      if (item.func == FUNC_TICK) begin
         case (phase_ff)
            PH_START1, PH_START2: begin
               case (half_ff)
                  2'd0: sda_mid = 1'b1;
                  2'd1: scl_mid = 1'b1;
                  2'd2: sda_mid = 1'b0;
                  default: scl_mid = 1'b0;
               endcase
            end
            PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
               if (half_ff == 2'd0) begin
                  sda_mid = (bits_ff < 4'd8) ? shift_ff[7] : 1'b1;
               end else if (half_ff == 2'd1) begin
                  scl_mid = 1'b1;
               end else begin
                  scl_mid = 1'b0;
               end
            end
            PH_RX: begin
               if (bits_ff < 4'd8) begin
                  if (half_ff == 2'd0) begin
                     sda_mid = 1'b1;
                  end else begin
                     scl_mid      = 1'b1;
                     scl_low_next = 1'b1;
                     if (bits_ff == 4'd7) begin
                        dv   = 1'b1;
                        rd   = rx_shift;
                        last = (left_ff <= 6'd1);
                     end
                  end
               end else begin
                  if (half_ff == 2'd0) begin
                     sda_mid = (left_ff > 6'd1) ? 1'b0 : 1'b1;
                  end else if (half_ff == 2'd1) begin
                     scl_mid = 1'b1;
                  end else begin
                     scl_mid       = 1'b0;
                     sda_high_next = 1'b1;
                  end
               end
            end
            PH_STOP_OK, PH_STOP_ERR: begin
               if (half_ff == 2'd0) begin
                  sda_mid = 1'b0;
               end else if (half_ff == 2'd1) begin
                  scl_mid = 1'b1;
               end else begin
                  sda_mid = 1'b1;
                  done    = 1'b1;
                  nack    = (phase_ff == PH_STOP_ERR);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      phase_in  = phase_ff;
      half_in   = half_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      reg_in    = reg_ff;
      value_in  = value_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      if (item.func == FUNC_START) begin
         if (phase_ff == PH_IDLE) begin
            kind_in  = item.is_read;
            reg_in   = item.reg_index;
            value_in = item.write_data;
            left_in  = (item.read_count > MAX_READ_LEN) ? MAX_READ_LEN : item.read_count;
            phase_in = PH_START1;
            half_in  = 2'd0;
            bits_in  = 4'd0;
         end
      end else begin
         scl_in = scl_low_next ? 1'b0 : scl_mid;
         sda_in = sda_high_next ? 1'b1 : sda_mid;
         case (phase_ff)
            PH_START1, PH_START2: begin
               if (half_ff != 2'd3) begin
                  half_in = half_ff + 2'd1;
               end else begin
                  phase_in = (phase_ff == PH_START1) ? PH_TX_ADDRW : PH_TX_ADDRR;
                  shift_in = {dev_addr, (phase_ff == PH_START2)};
                  bits_in  = 4'd0;
                  half_in  = 2'd0;
               end
            end
            PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
               if (half_ff == 2'd0) begin
                  half_in = 2'd1;
               end else if (half_ff == 2'd1) begin
                  if (bits_ff >= 4'd8 && item.sda_in) begin
                     bits_in = 4'd9;
                  end
                  half_in = 2'd2;
               end else begin
                  half_in = 2'd0;
                  if (bits_ff < 4'd8) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bits_in  = bits_ff + 4'd1;
                  end else if (bits_ff == 4'd9) begin
                     phase_in = PH_STOP_ERR;
                  end else begin
                     case (phase_ff)
                        PH_TX_ADDRW: begin
                           phase_in = PH_TX_REG;
                           shift_in = reg_ff;
                           bits_in  = 4'd0;
                        end
                        PH_TX_REG: begin
                           if (kind_ff) begin
                              phase_in = PH_START2;
                           end else begin
                              phase_in = PH_TX_DATA;
                              shift_in = value_ff;
                              bits_in  = 4'd0;
                           end
                        end
                        PH_TX_DATA: phase_in = PH_STOP_OK;
                        default: begin
                           if (left_ff == 6'd0) begin
                              phase_in = PH_STOP_OK;
                           end else begin
                              phase_in = PH_RX;
                              bits_in  = 4'd0;
                              shift_in = 8'd0;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_RX: begin
               if (bits_ff < 4'd8) begin
                  if (half_ff == 2'd0) begin
                     half_in = 2'd1;
                  end else begin
                     shift_in = rx_shift;
                     half_in  = 2'd0;
                     bits_in  = bits_ff + 4'd1;
                  end
               end else begin
                  if (half_ff == 2'd0) begin
                     half_in = 2'd1;
                  end else if (half_ff == 2'd1) begin
                     half_in = 2'd2;
                  end else begin
                     half_in = 2'd0;
                     left_in = left_dec;
                     if (left_dec == 6'd0) begin
                        phase_in = PH_STOP_OK;
                     end else begin
                        bits_in  = 4'd0;
                        shift_in = 8'd0;
                     end
                  end
               end
            end
            PH_STOP_OK, PH_STOP_ERR: begin
               if (half_ff == 2'd0) begin
                  half_in = 2'd1;
               end else if (half_ff == 2'd1) begin
                  half_in = 2'd2;
               end else begin
                  phase_in = PH_IDLE;
                  half_in  = 2'd0;
                  bits_in  = 4'd0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               half_in  = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         half_ff  <= 2'd0;
         bits_ff  <= 4'd0;
         shift_ff <= 8'd0;
         left_ff  <= 6'd0;
         kind_ff  <= 1'b0;
         reg_ff   <= 8'd0;
         value_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         half_ff  <= half_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         kind_ff  <= kind_in;
         reg_ff   <= reg_in;
         value_ff <= value_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   always_comb begin
      result.scl_release = (item.func == FUNC_TICK) ? scl_mid : scl_ff;
      result.sda_release = (item.func == FUNC_TICK) ? sda_mid : sda_ff;
      result.busy_res    = (phase_in != PH_IDLE);
      result.data_valid  = dv;
      result.read_data   = rd;
      result.last_byte   = last;
      result.done_res    = done;
      result.nack_error  = nack;
   end

endmodule

>>> rtl/i2c_register_access_master_core.sv
// Top level of the I2C register access master: stream ports, CSR port, result register.
//
// Each req transaction is either a start command (tuser 0) or one tick of half an SCL
// period (tuser 1); every req transaction yields exactly one rsp transaction carrying the
// SCL/SDA release levels for that half period, status and any received byte. The
// sequencer takes one step per transaction, so a new transaction is accepted every
// clock while the rsp side keeps up; the result is captured in an output register on
// acceptance. A write transaction runs start, address+W, register, data, stop; a burst
// read runs start, address+W, register, repeated start, address+R, N bytes (0..32,
// larger counts clamp to 32, zero reads none), stop. A missing ACK ends with stop and
// nack_error set alongside done_res. device_address (CSR 0x0) resets to 0x5A.
module i2c_register_access_master_core
   import i2crm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // is_read, reg_index[7:0], write_data[7:0],
                                             // read_count[5:0], sda_in
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // scl_release, sda_release, busy_res,
                                             // read_data[7:0], done_res, nack_error, zero pad
   output logic                  rsp_tuser,  // data_valid
   output logic                  rsp_tlast,  // last_byte
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [6:0]   dev_addr_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;
   rsp_item_type step_result;
   req_item_type req_item;
   logic         accept;
   logic         csr_write;
   logic         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_DEVICE_ADDRESS);
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-7){1'b0}}, dev_addr_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RESET;
      end else if (csr_write && csr_hit) begin
         dev_addr_ff <= csr_pwdata[6:0];
      end
   end

   assign req_item.func       = req_tuser;
   assign req_item.is_read    = req_tdata[0];
   assign req_item.reg_index  = req_tdata[8:1];
   assign req_item.write_data = req_tdata[16:9];
   assign req_item.read_count = req_tdata[22:17];
   assign req_item.sda_in     = req_tdata[23];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   i2crm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .item     (req_item),
      .dev_addr (dev_addr_ff),
      .result   (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff.nack_error, rsp_data_ff.done_res,
                        rsp_data_ff.read_data, rsp_data_ff.busy_res,
                        rsp_data_ff.sda_release, rsp_data_ff.scl_release};
   assign rsp_tuser  = rsp_data_ff.data_valid;
   assign rsp_tlast  = rsp_data_ff.last_byte;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("done reported while still busy");

   a_nack_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.nack_error |-> rsp_data_ff.done_res)
      else $error("nack reported without done");

   a_last_with_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last_byte |-> rsp_data_ff.data_valid
         && rsp_data_ff.busy_res)
      else $error("last byte flag without received byte");

   a_data_during_scl_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.data_valid |-> rsp_data_ff.scl_release)
      else $error("byte received while SCL driven low");
`endif

endmodule

>>> tb/i2c_register_access_master_core_tb.sv
// Testbench for the I2C register access master: streams checked against a bus-level predictor.
`timescale 1ns / 100ps

module i2c_register_access_master_core_tb;
   import i2crm_pkg::*;

   typedef enum logic [1:0] {RX_RANDOM, RX_ZEROS, RX_ONES} rx_fill_type;

   localparam logic [CSR_ADDR_W-1:0] DEV_ADDR_REG = {CSR_IDX_DEVICE_ADDRESS, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // is_read, reg_index[7:0], write_data[7:0],
                                       // read_count[5:0], sda_in
   logic                  req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;   // scl_release, sda_release, busy_res,
                                       // read_data[7:0], done_res, nack_error, zero pad
   logic                  rsp_tuser;   // data_valid
   logic                  rsp_tlast;   // last_byte
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   i2c_register_access_master_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int           error_count = 0;
   int           items_sent  = 0;
   bit           gaps_on     = 1'b1;
   bit           stalls_on   = 1'b1;
   rsp_item_type expected_bus_q[$];

   // predictor state
   logic [6:0] mdl_dev   = DEV_ADDR_RESET;
   phase_type  mdl_phase = PH_IDLE;
   logic [1:0] mdl_half  = '0;
   logic [3:0] mdl_bits  = '0;
   logic [7:0] mdl_shift = '0;
   logic [5:0] mdl_left  = '0;
   logic       mdl_kind  = 1'b0;
   logic [7:0] mdl_reg   = '0;
   logic [7:0] mdl_val   = '0;
   logic       mdl_scl   = 1'b1;
   logic       mdl_sda   = 1'b1;

   function automatic int pick_gap(input bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void load_tx_byte(input phase_type ph, input logic [7:0] value);
      mdl_phase = ph;
      mdl_shift = value;
      mdl_bits  = '0;
      mdl_half  = '0;
   endfunction

   function automatic rsp_item_type predict_bus_half_period(input req_item_type it);
      rsp_item_type r;
      logic         drop_scl;
      logic         raise_sda;
      r         = '0;
      drop_scl  = 1'b0;
      raise_sda = 1'b0;
      if (it.func == FUNC_START) begin
         if (mdl_phase == PH_IDLE) begin
            mdl_kind  = it.is_read;
            mdl_reg   = it.reg_index;
            mdl_val   = it.write_data;
            mdl_left  = (it.read_count > MAX_READ_LEN) ? MAX_READ_LEN : it.read_count;
            mdl_phase = PH_START1;
            mdl_half  = '0;
            mdl_bits  = '0;
         end
      end else begin
         case (mdl_phase)
            PH_START1, PH_START2: begin
               case (mdl_half)
                  2'd0: mdl_sda = 1'b1;
                  2'd1: mdl_scl = 1'b1;
                  2'd2: mdl_sda = 1'b0;
                  default: mdl_scl = 1'b0;
               endcase
               if (mdl_half < 2'd3) mdl_half = mdl_half + 2'd1;
               else if (mdl_phase == PH_START1) load_tx_byte(PH_TX_ADDRW, {mdl_dev, 1'b0});
               else load_tx_byte(PH_TX_ADDRR, {mdl_dev, 1'b1});
            end
            PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
               if (mdl_half == 2'd0) begin
                  mdl_sda  = (mdl_bits < 4'd8) ? mdl_shift[7] : 1'b1;
                  mdl_half = 2'd1;
               end else if (mdl_half == 2'd1) begin
                  mdl_scl = 1'b1;
                  if (mdl_bits >= 4'd8 && it.sda_in) mdl_bits = 4'd9;
                  mdl_half = 2'd2;
               end else begin
                  mdl_scl  = 1'b0;
                  mdl_half = 2'd0;
                  if (mdl_bits < 4'd8) begin
                     mdl_shift = mdl_shift << 1;
                     mdl_bits  = mdl_bits + 4'd1;
                  end else if (mdl_bits == 4'd9) begin
                     mdl_phase = PH_STOP_ERR;
                  end else begin
                     case (mdl_phase)
                        PH_TX_ADDRW: load_tx_byte(PH_TX_REG, mdl_reg);
                        PH_TX_REG: begin
                           if (mdl_kind) begin
                              mdl_phase = PH_START2;
                              mdl_half  = 2'd0;
                           end else begin
                              load_tx_byte(PH_TX_DATA, mdl_val);
                           end
                        end
                        PH_TX_DATA: begin
                           mdl_phase = PH_STOP_OK;
                           mdl_half  = 2'd0;
                        end
                        default: begin
                           mdl_half = 2'd0;
                           if (mdl_left == '0) begin
                              mdl_phase = PH_STOP_OK;
                           end else begin
                              mdl_phase = PH_RX;
                              mdl_bits  = '0;
                              mdl_shift = '0;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_RX: begin
               if (mdl_bits < 4'd8) begin
                  if (mdl_half == 2'd0) begin
                     mdl_sda  = 1'b1;
                     mdl_half = 2'd1;
                  end else begin
                     mdl_scl   = 1'b1;
                     drop_scl  = 1'b1;
                     mdl_shift = {mdl_shift[6:0], it.sda_in};
                     mdl_half  = 2'd0;
                     mdl_bits  = mdl_bits + 4'd1;
                     if (mdl_bits == 4'd8) begin
                        r.data_valid = 1'b1;
                        r.read_data  = mdl_shift;
                        r.last_byte  = (mdl_left <= 6'd1);
                     end
                  end
               end else if (mdl_half == 2'd0) begin
                  mdl_sda  = (mdl_left > 6'd1) ? 1'b0 : 1'b1;
                  mdl_half = 2'd1;
               end else if (mdl_half == 2'd1) begin
                  mdl_scl  = 1'b1;
                  mdl_half = 2'd2;
               end else begin
                  mdl_scl   = 1'b0;
                  raise_sda = 1'b1;
                  mdl_half  = 2'd0;
                  if (mdl_left > '0) mdl_left = mdl_left - 6'd1;
                  if (mdl_left == '0) begin
                     mdl_phase = PH_STOP_OK;
                  end else begin
                     mdl_bits  = '0;
                     mdl_shift = '0;
                  end
               end
            end
            PH_STOP_OK, PH_STOP_ERR: begin
               if (mdl_half == 2'd0) begin
                  mdl_sda  = 1'b0;
                  mdl_half = 2'd1;
               end else if (mdl_half == 2'd1) begin
                  mdl_scl  = 1'b1;
                  mdl_half = 2'd2;
               end else begin
                  mdl_sda      = 1'b1;
                  r.done_res   = 1'b1;
                  r.nack_error = (mdl_phase == PH_STOP_ERR);
                  mdl_phase    = PH_IDLE;
                  mdl_half     = '0;
                  mdl_bits     = '0;
               end
            end
            default: begin
               mdl_phase = PH_IDLE;
               mdl_half  = '0;
            end
         endcase
      end
      r.scl_release = mdl_scl;
      r.sda_release = mdl_sda;
      r.busy_res    = (mdl_phase != PH_IDLE);
      if (drop_scl) mdl_scl = 1'b0;
      if (raise_sda) mdl_sda = 1'b1;
      return r;
   endfunction

   function automatic req_item_type random_item(input logic func);
      req_item_type it;
      it.func       = func;
      it.is_read    = 1'($urandom_range(0, 1));
      it.reg_index  = 8'($urandom_range(0, 255));
      it.write_data = 8'($urandom_range(0, 255));
      it.read_count = 6'($urandom_range(0, 63));
      it.sda_in     = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endtask

   // valid stays high after a transaction; it drops only for a gap or at a drain
   task automatic send_bus_item(input req_item_type it);
      int gap;
      gap = pick_gap(gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {it.sda_in, it.read_count, it.write_data, it.reg_index, it.is_read};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_bus_q.push_back(predict_bus_half_period(it));
      items_sent++;
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (expected_bus_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= DEV_ADDR_REG;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_device_address(input logic [6:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      finish_phase();
      csr_access(1'b1, CSR_DATA_W'(value), rdata);
      mdl_dev = value;
      csr_access(1'b0, '0, rdata);
      check_field("device_address", value, rdata);
   endtask

   // Target side: ACKs every byte except the one in nack_at, feeds read bits per fill.
   task automatic run_transaction(input logic rd, input logic [7:0] reg_no,
                                  input logic [7:0] wval, input logic [5:0] count,
                                  input phase_type nack_at, input rx_fill_type fill,
                                  input int stray_pct);
      req_item_type it;
      it            = random_item(FUNC_START);
      it.is_read    = rd;
      it.reg_index  = reg_no;
      it.write_data = wval;
      it.read_count = count;
      send_bus_item(it);
      while (mdl_phase != PH_IDLE) begin
         it = random_item(FUNC_TICK);
         if ((mdl_phase == PH_TX_ADDRW || mdl_phase == PH_TX_REG ||
              mdl_phase == PH_TX_DATA || mdl_phase == PH_TX_ADDRR) &&
             mdl_bits >= 4'd8 && mdl_half == 2'd1) begin
            it.sda_in = (mdl_phase == nack_at);
         end else if (mdl_phase == PH_RX && mdl_bits < 4'd8 && mdl_half == 2'd1) begin
            if (fill == RX_ZEROS) it.sda_in = 1'b0;
            else if (fill == RX_ONES) it.sda_in = 1'b1;
         end
         send_bus_item(it);
         if (mdl_phase != PH_IDLE && $urandom_range(0, 99) < stray_pct)
            send_bus_item(random_item(FUNC_START));
      end
   endtask

   task automatic test_reset_value();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, '0, rdata);
      check_field("device_address", DEV_ADDR_RESET, rdata);
   endtask

   task automatic test_idle_ticks();
      req_item_type it;
      it = '1;
      send_bus_item(it);
      it = '0;
      it.func = FUNC_TICK;
      send_bus_item(it);
      repeat (3) send_bus_item(random_item(FUNC_TICK));
      finish_phase();
   endtask

   task automatic test_register_write();
      run_transaction(1'b0, 8'h00, 8'hFF, 6'd63, PH_IDLE, RX_RANDOM, 0);
      run_transaction(1'b0, 8'hFF, 8'h00, 6'd0, PH_IDLE, RX_RANDOM, 0);
      run_transaction(1'b0, 8'hA5, 8'h3C, 6'd5, PH_IDLE, RX_RANDOM, 0);
      finish_phase();
   endtask

   task automatic test_burst_read();
      run_transaction(1'b1, 8'h00, 8'hFF, 6'd1, PH_IDLE, RX_ONES, 0);
      run_transaction(1'b1, 8'hFF, 8'h00, 6'd3, PH_IDLE, RX_ZEROS, 0);
      run_transaction(1'b1, 8'h5A, 8'h81, 6'd2, PH_IDLE, RX_RANDOM, 0);
      finish_phase();
   endtask

   task automatic test_read_count_limits();
      run_transaction(1'b1, 8'h12, 8'h00, 6'd0, PH_IDLE, RX_RANDOM, 0);
      run_transaction(1'b1, 8'h56, 8'h00, 6'd33, PH_IDLE, RX_RANDOM, 0);
      finish_phase();
   endtask

   task automatic test_target_nack();
      run_transaction(1'b0, 8'h01, 8'h02, 6'd0, PH_TX_ADDRW, RX_RANDOM, 0);
      run_transaction(1'b0, 8'h03, 8'h04, 6'd0, PH_TX_REG, RX_RANDOM, 0);
      run_transaction(1'b0, 8'h05, 8'h06, 6'd0, PH_TX_DATA, RX_RANDOM, 0);
      run_transaction(1'b1, 8'h07, 8'h00, 6'd2, PH_TX_ADDRR, RX_RANDOM, 0);
      run_transaction(1'b1, 8'h09, 8'h00, 6'd2, PH_TX_REG, RX_RANDOM, 0);
      finish_phase();
   endtask

   task automatic test_stray_commands();
      run_transaction(1'b0, 8'hC3, 8'h7E, 6'd1, PH_IDLE, RX_RANDOM, 30);
      run_transaction(1'b1, 8'h3C, 8'hE7, 6'd2, PH_IDLE, RX_RANDOM, 30);
      finish_phase();
   endtask

   task automatic test_device_address();
      set_device_address(7'h00);
      run_transaction(1'b0, 8'h11, 8'h22, 6'd0, PH_IDLE, RX_RANDOM, 0);
      set_device_address(7'h7F);
      run_transaction(1'b1, 8'h33, 8'h00, 6'd1, PH_IDLE, RX_RANDOM, 0);
      set_device_address(7'($urandom_range(1, 126)));
      run_transaction(1'b1, 8'h44, 8'h00, 6'd1, PH_IDLE, RX_RANDOM, 0);
      set_device_address(DEV_ADDR_RESET);
   endtask

   task automatic test_random_traffic();
      int          start_count;
      int          seq;
      int          r;
      logic [5:0]  count;
      phase_type   nack_at;
      rx_fill_type fill;
      start_count = items_sent;
      seq         = 0;
      while (items_sent - start_count < 100) begin
         r         = $urandom_range(0, 4);
         gaps_on   = (r != 0);
         stalls_on = (r != 0);
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6)) send_bus_item(random_item(FUNC_TICK));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) count = 6'd0;
            else if (r < 75) count = 6'($urandom_range(1, 4));
            else if (r < 95) count = 6'($urandom_range(5, 32));
            else count = 6'($urandom_range(33, 63));
            r = $urandom_range(0, 99);
            if (r < 85) nack_at = PH_IDLE;
            else if (r < 89) nack_at = PH_TX_ADDRW;
            else if (r < 93) nack_at = PH_TX_REG;
            else if (r < 96) nack_at = PH_TX_DATA;
            else nack_at = PH_TX_ADDRR;
            r = $urandom_range(0, 9);
            fill = (r == 0) ? RX_ZEROS : (r == 1) ? RX_ONES : RX_RANDOM;
            run_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), count, nack_at, fill,
                            ($urandom_range(0, 4) == 0) ? 5 : 0);
         end
         seq++;
         if (seq % 20 == 0) set_device_address(7'($urandom_range(0, 127)));
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bus_q.size() == 0) begin
            error_count++;
            $error("rsp transaction with no expected result pending");
         end else begin
            want = expected_bus_q.pop_front();
            check_field("scl_release", want.scl_release, rsp_tdata[0]);
            check_field("sda_release", want.sda_release, rsp_tdata[1]);
            check_field("busy_res", want.busy_res, rsp_tdata[2]);
            check_field("read_data", want.read_data, rsp_tdata[10:3]);
            check_field("done_res", want.done_res, rsp_tdata[11]);
            check_field("nack_error", want.nack_error, rsp_tdata[12]);
            check_field("data_valid", want.data_valid, rsp_tuser);
            check_field("last_byte", want.last_byte, rsp_tlast);
         end
      end
   end

   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap(stalls_on);
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= FUNC_TICK;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_idle_ticks();
      test_register_write();
      test_burst_read();
      test_read_count_limits();
      test_target_nack();
      test_stray_commands();
      test_device_address();
      test_random_traffic();
      finish_phase();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
